// ----- hw/rtl/radial_gradient_pixel_core_assert.svh -----
// Assertion macros used by the checker of the gradient core.
`ifndef RADIAL_GRADIENT_PIXEL_CORE_ASSERT_SVH
`define RADIAL_GRADIENT_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rgp_pkg.sv -----
`timescale 1ns / 1ps
package rgp_pkg;

    // Fixed field widths.
    localparam int CFG_W    = 13;
    localparam int POS_W    = 12;
    localparam int CH_W     = 8;
    localparam int QUOT_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam int MAX_DIM_DEFAULT = 4096;
    // Widths that follow from the default size limit.
    localparam int DEF_DEN_W = 27;
    localparam int DEF_NUM_W = DEF_DEN_W + QUOT_W;

    // Front end stages before the divider, then one divider stage per bit.
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_DEPTH   = FRONT_STAGES + QUOT_W;

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_SIZE   = CFG_W'(256);
    localparam logic [CH_W-1:0]  RST_CENTRE = CH_W'(0);
    localparam logic [CH_W-1:0]  RST_CORNER = CH_W'(255);

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_CENTRE_RED   = 3'd2,
        REG_CENTRE_GREEN = 3'd3,
        REG_CENTRE_BLUE  = 3'd4,
        REG_CORNER_RED   = 3'd5,
        REG_CORNER_GREEN = 3'd6,
        REG_CORNER_BLUE  = 3'd7
    } rgp_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] pixel_x;
        logic [POS_W-1:0] pixel_y;
    } rgp_pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgp_color_t;

endpackage

// ----- hw/rtl/rgp_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, three channels
// sharing one divisor. The quotient must fit in QUOT_W bits.
module rgp_div import rgp_pkg::*; #(
    parameter int DEN_W = DEF_DEN_W,
    parameter int NUM_W = DEF_NUM_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [NUM_CH-1:0][NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]               divisor,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [NUM_CH-1:0][QUOT_W-1:0]  out_quot
);

    logic [NUM_CH-1:0][NUM_W-1:0]  rem_reg  [1:QUOT_W];
    logic [NUM_CH-1:0][QUOT_W-1:0] quot_reg [1:QUOT_W];
    logic [QUOT_W:1]               valid_reg;
    logic [QUOT_W:1]               adv;

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
        logic [NUM_CH-1:0][NUM_W-1:0]  rem_prev;
        logic [NUM_CH-1:0][QUOT_W-1:0] quot_prev;
        logic                          valid_prev;
        logic [NUM_CH-1:0][NUM_W-1:0]  rem_next;
        logic [NUM_CH-1:0][QUOT_W-1:0] quot_next;
        logic [NUM_W-1:0]              shifted;

        // stage input: ports for the first stage, previous stage otherwise
        if (k == 1) begin : g_first
            assign rem_prev   = in_num;
            assign quot_prev  = '0;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign quot_prev  = quot_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // a stage moves when it is empty or the next one moves
        if (k == QUOT_W) begin : g_last
            assign adv[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid
            assign adv[k] = !valid_reg[k] || adv[k+1];
        end

        assign shifted = NUM_W'(divisor) << (QUOT_W - k);

        // trial subtract per channel
        always_comb begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (rem_prev[c] >= shifted) begin
                    rem_next[c]  = rem_prev[c] - shifted;
                    quot_next[c] = {quot_prev[c][QUOT_W-2:0], 1'b1};
                end else begin
                    rem_next[c]  = rem_prev[c];
                    quot_next[c] = {quot_prev[c][QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
            end
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = valid_reg[QUOT_W];
    assign out_quot  = quot_reg[QUOT_W];

endmodule

// ----- hw/rtl/radial_gradient_pixel_core.sv -----
`timescale 1ns / 1ps
// Radial gradient pixel core: takes one pixel coordinate per word and returns
// its color, blended between the centre and corner colors by squared distance
// from the image centre. One pixel per clock is accepted and delivered while
// m_ready stays high; there are five front stages for distance, products and
// sums, then an eight-stage restoring divider, one quotient bit per stage. A
// stall on the result side backs up stage by stage, so bubbles are absorbed
// before s_ready drops. Size and color registers sit on the APB port and must
// be written only while the pipeline is empty; the derived distance terms
// settle through the square, full-scale and divisor registers after a write.
module radial_gradient_pixel_core import rgp_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  rgp_pixel_t         s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rgp_color_t         m_data
);

    localparam int LOG_DIM = $clog2(MAX_DIM + 1);
    localparam int DW      = (LOG_DIM > CFG_W) ? LOG_DIM : CFG_W;
    localparam int SW      = 2 * DW;
    localparam int DDW     = SW + 1;
    localparam int NW      = DDW + QUOT_W;

    // Configuration registers
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [NUM_CH-1:0][CH_W-1:0] centre_reg, corner_reg;
    rgp_reg_t reg_idx;

    assign reg_idx = rgp_reg_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_SIZE;
            height_reg <= RST_SIZE;
            centre_reg <= {NUM_CH{RST_CENTRE}};
            corner_reg <= {NUM_CH{RST_CORNER}};
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg     <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= pwdata[CFG_W-1:0];
                REG_CENTRE_RED:   centre_reg[0] <= pwdata[CH_W-1:0];
                REG_CENTRE_GREEN: centre_reg[1] <= pwdata[CH_W-1:0];
                REG_CENTRE_BLUE:  centre_reg[2] <= pwdata[CH_W-1:0];
                REG_CORNER_RED:   corner_reg[0] <= pwdata[CH_W-1:0];
                REG_CORNER_GREEN: corner_reg[1] <= pwdata[CH_W-1:0];
                REG_CORNER_BLUE:  corner_reg[2] <= pwdata[CH_W-1:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_CENTRE_RED:   prdata = PDATA_W'(centre_reg[0]);
            REG_CENTRE_GREEN: prdata = PDATA_W'(centre_reg[1]);
            REG_CENTRE_BLUE:  prdata = PDATA_W'(centre_reg[2]);
            REG_CORNER_RED:   prdata = PDATA_W'(corner_reg[0]);
            REG_CORNER_GREEN: prdata = PDATA_W'(corner_reg[1]);
            REG_CORNER_BLUE:  prdata = PDATA_W'(corner_reg[2]);
        endcase
    end

    // Clamped sizes and the derived full-scale distance
    logic [DW-1:0]  w_clamp, h_clamp;
    logic [SW-1:0]  wsq_reg, hsq_reg;
    logic [DDW-1:0] dmax_reg, div_reg;
    logic           dmax_zero;

    assign w_clamp = (DW'(width_reg) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_reg);
    assign h_clamp = (DW'(height_reg) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_reg);
    assign dmax_zero = (dmax_reg == '0);

    always_ff @(posedge aclk) begin
        wsq_reg  <= SW'(w_clamp) * SW'(w_clamp);
        hsq_reg  <= SW'(h_clamp) * SW'(h_clamp);
        dmax_reg <= DDW'(wsq_reg) + DDW'(hsq_reg);
        // zero full-scale distance divides by one with the centre color as numerator
        div_reg  <= dmax_zero ? DDW'(1) : dmax_reg;
    end

    // Stage handshake chain
    logic [FRONT_STAGES:1] valid_reg;
    logic [FRONT_STAGES:1] adv;
    logic                  div_ready;

    always_comb begin
        adv[FRONT_STAGES] = !valid_reg[FRONT_STAGES] || div_ready;
        for (int k = FRONT_STAGES - 1; k >= 1; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[1]) valid_reg[1] <= s_valid;
            for (int k = 2; k <= FRONT_STAGES; k++) begin
                if (adv[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 1: distance from centre per axis, doubled coordinates
    logic [DW-1:0] twice_x, twice_y, dx_next, dy_next;
    logic [DW-1:0] dx_reg, dy_reg;

    assign twice_x = DW'({s_data.pixel_x, 1'b0});
    assign twice_y = DW'({s_data.pixel_y, 1'b0});
    assign dx_next = (twice_x >= w_clamp) ? twice_x - w_clamp : w_clamp - twice_x;
    assign dy_next = (twice_y >= h_clamp) ? twice_y - h_clamp : h_clamp - twice_y;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Stage 2: squares
    logic [SW-1:0] sqx_reg, sqy_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            sqx_reg <= SW'(dx_reg) * SW'(dx_reg);
            sqy_reg <= SW'(dy_reg) * SW'(dy_reg);
        end
    end

    // Stage 3: distance, saturated at full scale
    logic [DDW-1:0] dsum;
    logic [DDW-1:0] d_reg;

    assign dsum = DDW'(sqx_reg) + DDW'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            d_reg <= (dsum > dmax_reg) ? dmax_reg : dsum;
        end
    end

    // Stage 4: weighted products per channel
    logic [NUM_CH-1:0][NW-1:0] pcorner_reg, pcentre_reg;
    logic [DDW-1:0]            drest;

    assign drest = dmax_reg - d_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                pcorner_reg[c] <= NW'(corner_reg[c]) * NW'(d_reg);
                pcentre_reg[c] <= NW'(centre_reg[c]) * NW'(drest);
            end
        end
    end

    // Stage 5: numerators
    logic [NUM_CH-1:0][NW-1:0] num_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                num_reg[c] <= dmax_zero ? NW'(centre_reg[c])
                                        : pcorner_reg[c] + pcentre_reg[c];
            end
        end
    end

    // Divider; its last stage is the output register
    logic [NUM_CH-1:0][QUOT_W-1:0] quot;

    rgp_div #(
        .DEN_W (DDW),
        .NUM_W (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg[FRONT_STAGES]),
        .in_ready  (div_ready),
        .in_num    (num_reg),
        .divisor   (div_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_quot  (quot)
    );

    assign m_data.red   = quot[0];
    assign m_data.green = quot[1];
    assign m_data.blue  = quot[2];

endmodule

// ----- hw/rtl/rgp_checker.sv -----
`timescale 1ns / 1ps
`include "radial_gradient_pixel_core_assert.svh"
module rgp_checker import rgp_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input rgp_color_t m_data
);

    // words in flight between the two channels
    logic [$clog2(PIPE_DEPTH+2)-1:0] cnt_reg, cnt_next;
    logic in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc) cnt_next = cnt_reg + 1'b1;
        if (!in_acc && out_acc) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `RGP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `RGP_ASSERT_NOW(a_no_phantom, m_valid, cnt_reg != '0, "result word with no pixel in flight")
    `RGP_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= PIPE_DEPTH, "more words in flight than stages")
    `RGP_ASSERT_NOW(a_full_stall, !s_ready, m_valid && !m_ready, "input stalled while output drains")

endmodule

bind radial_gradient_pixel_core rgp_checker u_rgp_checker (.*);
